@@ hdl/stable_priority_queue_assert.svh @@
//------------------------------------------------------------------------------
// stable_priority_queue_assert.svh
// Assertion macros shared by the queue checker.
//------------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ hdl/spq_pkg.sv @@
//------------------------------------------------------------------------------
// spq_pkg
// Types and constants for the stable priority queue.
//------------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int ID_BITS    = 8;
    localparam int LEVEL_BITS = 8;
    localparam int FILL_BITS  = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [ID_BITS-1:0]    item_id;
        logic [LEVEL_BITS-1:0] item_priority;
    } t_in_word;

    typedef struct packed {
        logic                  head_valid;
        logic [ID_BITS-1:0]    head_id;
        logic [LEVEL_BITS-1:0] head_level;
        logic [FILL_BITS-1:0]  fill_count;
        logic                  overflow;
    } t_out_word;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [ID_BITS-1:0]    id;
        logic [LEVEL_BITS-1:0] level;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
//------------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, shifts down on insert, shifts up on pop.
//------------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic                           i_clk,
    input  wire spq_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic                           i_occ,
    input  wire logic                           i_prev_keep,
    input  wire logic [spq_pkg::ID_BITS-1:0]    i_prev_id,
    input  wire logic [spq_pkg::LEVEL_BITS-1:0] i_prev_level,
    input  wire logic [spq_pkg::ID_BITS-1:0]    i_next_id,
    input  wire logic [spq_pkg::LEVEL_BITS-1:0] i_next_level,
    output logic                                o_keep,
    output logic [spq_pkg::ID_BITS-1:0]         o_id,
    output logic [spq_pkg::LEVEL_BITS-1:0]      o_level,
    output logic [spq_pkg::ID_BITS-1:0]         o_next_id,
    output logic [spq_pkg::LEVEL_BITS-1:0]      o_next_level
);

    logic [spq_pkg::ID_BITS-1:0]    r_id;
    logic [spq_pkg::LEVEL_BITS-1:0] r_level;
    logic [spq_pkg::ID_BITS-1:0]    n_id;
    logic [spq_pkg::LEVEL_BITS-1:0] n_level;
    logic                           w_keep;

    // stays ahead of an incoming word of equal or lower priority
    assign w_keep = i_occ && (r_level >= i_ctrl.level);

    always_comb begin
        n_id    = r_id;
        n_level = r_level;
        if (i_ctrl.push) begin
            if (!w_keep) begin
                if (i_prev_keep) begin
                    n_id    = i_ctrl.id;
                    n_level = i_ctrl.level;
                end else begin
                    n_id    = i_prev_id;
                    n_level = i_prev_level;
                end
            end
        end else if (i_ctrl.pop) begin
            n_id    = i_next_id;
            n_level = i_next_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_level <= n_level;
    end

    assign o_keep       = w_keep;
    assign o_id         = r_id;
    assign o_level      = r_level;
    assign o_next_id    = n_id;
    assign o_next_level = n_level;

endmodule

`default_nettype wire

@@ hdl/stable_priority_queue.sv @@
// A result word is registered; it appears in the cycle after its input is taken.
// Throughput: one push or pop per cycle unless stalled; every cell compares and
// shifts at once. The output register is the only buffer; input stalls only
// while it holds a word that the output side stalls.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// slot contents are not cleared.
//------------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue built as a sorted chain of slot cells.
//------------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire spq_pkg::t_in_word i_word,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output spq_pkg::t_out_word     o_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int FB = spq_pkg::FILL_BITS;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    spq_pkg::t_out_word     r_out_word;
    spq_pkg::t_out_word     n_out_word;
    spq_pkg::t_cell_ctrl    w_ctrl;
    logic                   w_accept;
    logic                   w_empty;
    logic                   w_full;
    logic [FB+CW-1:0]       w_fill_ext;

    logic [DEPTH-1:0]                  w_keep;
    logic [spq_pkg::ID_BITS-1:0]       w_id     [DEPTH];
    logic [spq_pkg::LEVEL_BITS-1:0]    w_level  [DEPTH];
    logic [spq_pkg::ID_BITS-1:0]       w_nid    [DEPTH];
    logic [spq_pkg::LEVEL_BITS-1:0]    w_nlevel [DEPTH];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(DEPTH));

    assign w_ctrl.push  = w_accept && (i_word.kind == spq_pkg::KIND_PUSH) && !w_full;
    assign w_ctrl.pop   = w_accept && (i_word.kind == spq_pkg::KIND_POP) && !w_empty;
    assign w_ctrl.id    = i_word.item_id;
    assign w_ctrl.level = i_word.item_priority;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                           w_prev_keep;
            logic [spq_pkg::ID_BITS-1:0]    w_prev_id;
            logic [spq_pkg::LEVEL_BITS-1:0] w_prev_level;
            logic [spq_pkg::ID_BITS-1:0]    w_next_id;
            logic [spq_pkg::LEVEL_BITS-1:0] w_next_level;

            if (g == 0) begin : g_head
                assign w_prev_keep  = 1'b1;
                assign w_prev_id    = i_word.item_id;
                assign w_prev_level = i_word.item_priority;
            end else begin : g_body
                assign w_prev_keep  = w_keep[g-1];
                assign w_prev_id    = w_id[g-1];
                assign w_prev_level = w_level[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_id    = w_id[g];
                assign w_next_level = w_level[g];
            end else begin : g_mid
                assign w_next_id    = w_id[g+1];
                assign w_next_level = w_level[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occ        (CW'(g) < r_count),
                .i_prev_keep  (w_prev_keep),
                .i_prev_id    (w_prev_id),
                .i_prev_level (w_prev_level),
                .i_next_id    (w_next_id),
                .i_next_level (w_next_level),
                .o_keep       (w_keep[g]),
                .o_id         (w_id[g]),
                .o_level      (w_level[g]),
                .o_next_id    (w_nid[g]),
                .o_next_level (w_nlevel[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_fill_ext = {{FB{1'b0}}, n_count};

    always_comb begin
        n_out_word            = '0;
        n_out_word.head_valid = (n_count != '0);
        if (n_count != '0) begin
            n_out_word.head_id    = w_nid[0];
            n_out_word.head_level = w_nlevel[0];
        end
        n_out_word.fill_count = w_fill_ext[FB-1:0];
        n_out_word.overflow   = w_accept && (i_word.kind == spq_pkg::KIND_PUSH) && w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

`default_nettype wire

@@ hdl/spq_checker.sv @@
//------------------------------------------------------------------------------
// spq_checker
// Port-level checks on the queue's result words, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_assert.svh"

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire spq_pkg::t_in_word  i_word,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire spq_pkg::t_out_word o_word
);

    localparam logic [spq_pkg::FILL_BITS-1:0] FULL_FILL = spq_pkg::FILL_BITS'(DEPTH);

    logic w_in_acc;
    logic w_out_acc;
    logic w_push_acc;
    logic w_empty_ok;
    logic w_full_ok;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_acc  = o_valid && !i_stall;
    assign w_push_acc = w_in_acc && (i_word.kind == spq_pkg::KIND_PUSH);
    assign w_empty_ok = (o_word.head_id == '0) && (o_word.head_level == '0)
                        && (o_word.fill_count == '0);
    assign w_full_ok  = o_word.head_valid && (o_word.fill_count == FULL_FILL);

    `SPQ_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && !o_word.head_valid, w_empty_ok)
    `SPQ_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, o_valid && o_word.overflow, w_full_ok)
    `SPQ_ASSERT_NXT(a_drained, i_clk, i_rst_n, w_out_acc && !w_in_acc, !o_valid)
    `SPQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word))
    `SPQ_ASSERT_NXT(a_push_head, i_clk, i_rst_n, w_push_acc, o_valid && o_word.head_valid)

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire
